/* hdl/sha256_pkg.sv */
// ----------------------------------------------------------------------------
// sha256_pkg
// Constants and round functions shared by the SHA-256 stream hasher.
// ----------------------------------------------------------------------------
package sha256_pkg;

  localparam int WORD_W  = 32;
  localparam int BYTE_W  = 8;
  localparam int CNT_W   = 61;
  localparam int ROUND_W = 6;
  localparam int BADDR_W = 4;
  localparam int HIDX_W  = 3;

  localparam logic [BYTE_W-1:0] PAD_BYTE = 8'h80;

  function automatic logic [WORD_W-1:0] rotr(input logic [WORD_W-1:0] v, input int n);
    rotr = (v >> n) | (v << (WORD_W - n));
  endfunction

  function automatic logic [WORD_W-1:0] big_sigma0(input logic [WORD_W-1:0] v);
    big_sigma0 = rotr(v, 2) ^ rotr(v, 13) ^ rotr(v, 22);
  endfunction

  function automatic logic [WORD_W-1:0] big_sigma1(input logic [WORD_W-1:0] v);
    big_sigma1 = rotr(v, 6) ^ rotr(v, 11) ^ rotr(v, 25);
  endfunction

  function automatic logic [WORD_W-1:0] small_sigma0(input logic [WORD_W-1:0] v);
    small_sigma0 = rotr(v, 7) ^ rotr(v, 18) ^ (v >> 3);
  endfunction

  function automatic logic [WORD_W-1:0] small_sigma1(input logic [WORD_W-1:0] v);
    small_sigma1 = rotr(v, 17) ^ rotr(v, 19) ^ (v >> 10);
  endfunction

  function automatic logic [WORD_W-1:0] init_hash(input logic [HIDX_W-1:0] idx);
    case (idx)
      3'd0:    init_hash = 32'h6a09e667;
      3'd1:    init_hash = 32'hbb67ae85;
      3'd2:    init_hash = 32'h3c6ef372;
      3'd3:    init_hash = 32'ha54ff53a;
      3'd4:    init_hash = 32'h510e527f;
      3'd5:    init_hash = 32'h9b05688c;
      3'd6:    init_hash = 32'h1f83d9ab;
      default: init_hash = 32'h5be0cd19;
    endcase
  endfunction

  function automatic logic [WORD_W-1:0] round_k(input logic [ROUND_W-1:0] idx);
    case (idx)
      6'd0:  round_k = 32'h428a2f98;  6'd1:  round_k = 32'h71374491;
      6'd2:  round_k = 32'hb5c0fbcf;  6'd3:  round_k = 32'he9b5dba5;
      6'd4:  round_k = 32'h3956c25b;  6'd5:  round_k = 32'h59f111f1;
      6'd6:  round_k = 32'h923f82a4;  6'd7:  round_k = 32'hab1c5ed5;
      6'd8:  round_k = 32'hd807aa98;  6'd9:  round_k = 32'h12835b01;
      6'd10: round_k = 32'h243185be;  6'd11: round_k = 32'h550c7dc3;
      6'd12: round_k = 32'h72be5d74;  6'd13: round_k = 32'h80deb1fe;
      6'd14: round_k = 32'h9bdc06a7;  6'd15: round_k = 32'hc19bf174;
      6'd16: round_k = 32'he49b69c1;  6'd17: round_k = 32'hefbe4786;
      6'd18: round_k = 32'h0fc19dc6;  6'd19: round_k = 32'h240ca1cc;
      6'd20: round_k = 32'h2de92c6f;  6'd21: round_k = 32'h4a7484aa;
      6'd22: round_k = 32'h5cb0a9dc;  6'd23: round_k = 32'h76f988da;
      6'd24: round_k = 32'h983e5152;  6'd25: round_k = 32'ha831c66d;
      6'd26: round_k = 32'hb00327c8;  6'd27: round_k = 32'hbf597fc7;
      6'd28: round_k = 32'hc6e00bf3;  6'd29: round_k = 32'hd5a79147;
      6'd30: round_k = 32'h06ca6351;  6'd31: round_k = 32'h14292967;
      6'd32: round_k = 32'h27b70a85;  6'd33: round_k = 32'h2e1b2138;
      6'd34: round_k = 32'h4d2c6dfc;  6'd35: round_k = 32'h53380d13;
      6'd36: round_k = 32'h650a7354;  6'd37: round_k = 32'h766a0abb;
      6'd38: round_k = 32'h81c2c92e;  6'd39: round_k = 32'h92722c85;
      6'd40: round_k = 32'ha2bfe8a1;  6'd41: round_k = 32'ha81a664b;
      6'd42: round_k = 32'hc24b8b70;  6'd43: round_k = 32'hc76c51a3;
      6'd44: round_k = 32'hd192e819;  6'd45: round_k = 32'hd6990624;
      6'd46: round_k = 32'hf40e3585;  6'd47: round_k = 32'h106aa070;
      6'd48: round_k = 32'h19a4c116;  6'd49: round_k = 32'h1e376c08;
      6'd50: round_k = 32'h2748774c;  6'd51: round_k = 32'h34b0bcb5;
      6'd52: round_k = 32'h391c0cb3;  6'd53: round_k = 32'h4ed8aa4a;
      6'd54: round_k = 32'h5b9cca4f;  6'd55: round_k = 32'h682e6ff3;
      6'd56: round_k = 32'h748f82ee;  6'd57: round_k = 32'h78a5636f;
      6'd58: round_k = 32'h84c87814;  6'd59: round_k = 32'h8cc70208;
      6'd60: round_k = 32'h90befffa;  6'd61: round_k = 32'ha4506ceb;
      6'd62: round_k = 32'hbef9a3f7;  default: round_k = 32'hc67178f2;
    endcase
  endfunction

endpackage

/* hdl/sha256_stream_hasher.sv */
// ----------------------------------------------------------------------------
// sha256_stream_hasher
// SHA-256 over a byte stream, one message byte per input word, with padding
// and a digest of eight 32-bit words at the end of each message.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid/in_ready) carries one byte per word. A word
//   with in_end_of_message set closes the message; for an empty message it
//   carries no byte (in_byte_present low). A word with neither a byte nor the
//   end mark is dropped.
//   Bytes are packed into 32-bit words and kept in a 16-word block memory.
//   Each full 64-byte block runs the compression: a load step that starts the
//   memory read, 64 rounds at one per cycle and a fold step that adds the
//   result into the chaining words, during which in_ready is low.
//   At the end of a message the padding words are formed on the fly as the
//   block memory is read: one final block, or two when 56 or more bytes
//   are left in the last block.
//   The digest then leaves through the output register on the result
//   channel, word 0 first, out_digest_last high on word 7. A stall on the
//   receiver holds the current word; the block goes back to taking bytes
//   once word 7 sits in the output register.
//   Bytes are taken at one per cycle in the idle state only; none are taken during compression or digest output.
//   Reset (rst_n low, synchronous) loads the initial hash values, clears the
//   byte count and drops any pending output word.
// ----------------------------------------------------------------------------
module sha256_stream_hasher (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_byte_present,
  input  logic        in_end_of_message,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_digest_word,
  output logic        out_digest_last
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_ROUND,
    ST_FOLD,
    ST_OUT
  } state_t;

  typedef enum logic [1:0] {
    BLK_MSG,
    BLK_PAD1,
    BLK_PAD2
  } blk_kind_t;

  localparam int W = sha256_pkg::WORD_W;

  state_t    state_r, state_nxt;
  blk_kind_t blk_r, blk_nxt;
  logic      eom_r, eom_nxt;

  logic [sha256_pkg::CNT_W-1:0]   count_r, count_nxt;
  logic [23:0]                    acc_r, acc_nxt;
  logic [sha256_pkg::ROUND_W-1:0] rnd_r, rnd_nxt;
  logic [sha256_pkg::HIDX_W-1:0]  oidx_r, oidx_nxt;

  logic [W-1:0] cv_r    [8];
  logic [W-1:0] cv_nxt  [8];
  logic [W-1:0] st_r    [8];
  logic [W-1:0] st_nxt  [8];
  logic [W-1:0] sch_r   [16];
  logic [W-1:0] sch_nxt [16];

  logic         out_valid_r, out_valid_nxt;
  logic [W-1:0] out_word_r, out_word_nxt;
  logic         out_last_r, out_last_nxt;

  // Block memory: 16 words, one write and one registered read per cycle.
  logic [W-1:0]                   buf_mem [16];
  logic [W-1:0]                   mem_q_r;
  logic                           mem_we;
  logic [sha256_pkg::BADDR_W-1:0] mem_wa;
  logic [W-1:0]                   mem_wd;
  logic [sha256_pkg::BADDR_W-1:0] mem_ra;

  logic         in_acc;
  logic         out_load;
  logic [63:0]  bit_len;
  logic [W-1:0] tail_word;
  logic [W-1:0] w_cur;
  logic [W-1:0] t1;
  logic [W-1:0] t2;
  logic         len_in_pad1;
  logic [sha256_pkg::BADDR_W-1:0] widx;
  logic [sha256_pkg::BADDR_W-1:0] tail_idx;

  assign in_ready        = (state_r == ST_IDLE);
  assign in_acc          = in_valid && in_ready;
  assign out_valid       = out_valid_r;
  assign out_digest_word = out_word_r;
  assign out_digest_last = out_last_r;
  assign out_load        = (state_r == ST_OUT) && (!out_valid_r || out_ready);

  assign bit_len     = {count_r, 3'b000};
  assign len_in_pad1 = (count_r[5:3] != 3'b111);
  assign widx        = rnd_r[3:0];
  assign tail_idx    = count_r[5:2];

  // Last, partly filled word of the message with the 0x80 marker behind it.
  always_comb begin
    case (count_r[1:0])
      2'd0:    tail_word = {sha256_pkg::PAD_BYTE, 24'h0};
      2'd1:    tail_word = {acc_r[7:0], sha256_pkg::PAD_BYTE, 16'h0};
      2'd2:    tail_word = {acc_r[15:0], sha256_pkg::PAD_BYTE, 8'h0};
      default: tail_word = {acc_r[23:0], sha256_pkg::PAD_BYTE};
    endcase
  end

  // Schedule word for the current round.
  always_comb begin
    w_cur = '0;
    if (rnd_r[5:4] != 2'b00) begin
      w_cur = sch_r[0] + sha256_pkg::small_sigma0(sch_r[1]) + sch_r[9]
            + sha256_pkg::small_sigma1(sch_r[14]);
    end else begin
      case (blk_r)
        BLK_MSG: begin
          w_cur = mem_q_r;
        end
        BLK_PAD1: begin
          if (widx < tail_idx) begin
            w_cur = mem_q_r;
          end else if (widx == tail_idx) begin
            w_cur = tail_word;
          end else if (len_in_pad1 && widx == 4'd14) begin
            w_cur = bit_len[63:32];
          end else if (len_in_pad1 && widx == 4'd15) begin
            w_cur = bit_len[31:0];
          end
        end
        BLK_PAD2: begin
          if (widx == 4'd14) begin
            w_cur = bit_len[63:32];
          end else if (widx == 4'd15) begin
            w_cur = bit_len[31:0];
          end
        end
        default: begin
          w_cur = '0;
        end
      endcase
    end
  end

  assign t1 = st_r[7] + sha256_pkg::big_sigma1(st_r[4])
            + ((st_r[4] & st_r[5]) ^ (~st_r[4] & st_r[6]))
            + sha256_pkg::round_k(rnd_r) + w_cur;
  assign t2 = sha256_pkg::big_sigma0(st_r[0])
            + ((st_r[0] & st_r[1]) ^ (st_r[0] & st_r[2]) ^ (st_r[1] & st_r[2]));

  always_comb begin
    state_nxt     = state_r;
    blk_nxt       = blk_r;
    eom_nxt       = eom_r;
    count_nxt     = count_r;
    acc_nxt       = acc_r;
    rnd_nxt       = rnd_r;
    oidx_nxt      = oidx_r;
    cv_nxt        = cv_r;
    st_nxt        = st_r;
    sch_nxt       = sch_r;
    out_word_nxt  = out_word_r;
    out_last_nxt  = out_last_r;
    out_valid_nxt = out_valid_r;
    mem_we        = 1'b0;
    mem_wa        = count_r[5:2];
    mem_wd        = {acc_r, in_data_byte};
    mem_ra        = '0;

    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          eom_nxt = in_end_of_message;
          if (in_byte_present) begin
            acc_nxt   = {acc_r[15:0], in_data_byte};
            count_nxt = count_r + 61'd1;
            mem_we    = (count_r[1:0] == 2'd3);
          end
          if (in_byte_present && count_r[5:0] == 6'd63) begin
            blk_nxt   = BLK_MSG;
            state_nxt = ST_LOAD;
          end else if (in_end_of_message) begin
            blk_nxt   = BLK_PAD1;
            state_nxt = ST_LOAD;
          end
        end
      end
      ST_LOAD: begin
        mem_ra    = '0;
        st_nxt    = cv_r;
        rnd_nxt   = '0;
        state_nxt = ST_ROUND;
      end
      ST_ROUND: begin
        mem_ra = widx + 4'd1;
        for (int i = 0; i < 15; i++) begin
          sch_nxt[i] = sch_r[i+1];
        end
        sch_nxt[15] = w_cur;
        st_nxt[7]   = st_r[6];
        st_nxt[6]   = st_r[5];
        st_nxt[5]   = st_r[4];
        st_nxt[4]   = st_r[3] + t1;
        st_nxt[3]   = st_r[2];
        st_nxt[2]   = st_r[1];
        st_nxt[1]   = st_r[0];
        st_nxt[0]   = t1 + t2;
        rnd_nxt     = rnd_r + 6'd1;
        if (rnd_r == 6'd63) begin
          state_nxt = ST_FOLD;
        end
      end
      ST_FOLD: begin
        for (int i = 0; i < 8; i++) begin
          cv_nxt[i] = cv_r[i] + st_r[i];
        end
        oidx_nxt = '0;
        case (blk_r)
          BLK_MSG: begin
            if (eom_r) begin
              blk_nxt   = BLK_PAD1;
              state_nxt = ST_LOAD;
            end else begin
              state_nxt = ST_IDLE;
            end
          end
          BLK_PAD1: begin
            if (len_in_pad1) begin
              state_nxt = ST_OUT;
            end else begin
              blk_nxt   = BLK_PAD2;
              state_nxt = ST_LOAD;
            end
          end
          default: begin
            state_nxt = ST_OUT;
          end
        endcase
      end
      ST_OUT: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          out_word_nxt  = cv_r[oidx_r];
          out_last_nxt  = (oidx_r == 3'd7);
          oidx_nxt      = oidx_r + 3'd1;
          if (oidx_r == 3'd7) begin
            // Digest handed off: start over for the next message.
            for (int i = 0; i < 8; i++) begin
              cv_nxt[i] = sha256_pkg::init_hash(3'(i));
            end
            count_nxt = '0;
            eom_nxt   = 1'b0;
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      buf_mem[mem_wa] <= mem_wd;
    end
    mem_q_r <= buf_mem[mem_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      blk_r       <= BLK_MSG;
      eom_r       <= 1'b0;
      count_r     <= '0;
      rnd_r       <= '0;
      oidx_r      <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < 8; i++) begin
        cv_r[i] <= sha256_pkg::init_hash(3'(i));
      end
    end else begin
      state_r     <= state_nxt;
      blk_r       <= blk_nxt;
      eom_r       <= eom_nxt;
      count_r     <= count_nxt;
      rnd_r       <= rnd_nxt;
      oidx_r      <= oidx_nxt;
      out_valid_r <= out_valid_nxt;
      cv_r        <= cv_nxt;
    end
    acc_r      <= acc_nxt;
    st_r       <= st_nxt;
    sch_r      <= sch_nxt;
    out_word_r <= out_word_nxt;
    out_last_r <= out_last_nxt;
  end

endmodule

/* tb/sha256_stream_hasher_tb.sv */
// ----------------------------------------------------------------------------
// sha256_stream_hasher_tb
// Streams messages into the hasher one byte word at a time and checks every
// digest word against a behavioral SHA-256 held in a small scoreboard.
// Short directed messages come first, then random messages: short ones and
// lengths around the padding boundaries. Both channels stall at random.
// ----------------------------------------------------------------------------
module sha256_stream_hasher_tb;

  localparam int WORD_W = sha256_pkg::WORD_W;
  localparam int BYTE_W = sha256_pkg::BYTE_W;
  localparam int CNT_W  = sha256_pkg::CNT_W;

  localparam logic [BYTE_W-1:0] PAD_BYTE = sha256_pkg::PAD_BYTE;

  localparam int CLK_HALF    = 10;
  localparam int RESET_LEN   = 7;
  localparam int IDLE_PCT    = 19;
  localparam int RAND_WORDS  = 200;
  localparam int DRAIN_WAIT  = 80;
  localparam int CYCLE_LIMIT = 400000;

  localparam logic [WORD_W-1:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [WORD_W-1:0] START_HASH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic              last;
  } digest_word_t;

  class digest_scoreboard;
    logic [WORD_W-1:0] chain [8];
    logic [BYTE_W-1:0] blk [64];
    logic [CNT_W-1:0]  nbytes;
    digest_word_t      pending_digest [$];
    int                mismatches;

    function new();
      mismatches = 0;
      restart();
    endfunction

    function void restart();
      foreach (chain[i]) chain[i] = START_HASH[i];
      foreach (blk[i]) blk[i] = '0;
      nbytes = '0;
    endfunction

    function logic [WORD_W-1:0] ror_word(logic [WORD_W-1:0] v, int n);
      logic [2*WORD_W-1:0] dbl;
      dbl = {v, v} >> n;
      return dbl[WORD_W-1:0];
    endfunction

    function void sha_compress();
      logic [WORD_W-1:0] sched [64];
      logic [WORD_W-1:0] s [8];
      logic [WORD_W-1:0] t1, t2, lo, hi;
      for (int r = 0; r < 16; r++)
        sched[r] = {blk[4*r], blk[4*r+1], blk[4*r+2], blk[4*r+3]};
      for (int r = 16; r < 64; r++) begin
        lo = sched[r-15];
        hi = sched[r-2];
        sched[r] = sched[r-16] + sched[r-7]
                 + (ror_word(lo, 7) ^ ror_word(lo, 18) ^ (lo >> 3))
                 + (ror_word(hi, 17) ^ ror_word(hi, 19) ^ (hi >> 10));
      end
      foreach (s[i]) s[i] = chain[i];
      for (int r = 0; r < 64; r++) begin
        t1 = s[7] + (ror_word(s[4], 6) ^ ror_word(s[4], 11) ^ ror_word(s[4], 25))
           + ((s[4] & s[5]) ^ (~s[4] & s[6])) + ROUND_K[r] + sched[r];
        t2 = (ror_word(s[0], 2) ^ ror_word(s[0], 13) ^ ror_word(s[0], 22))
           + ((s[0] & s[1]) ^ (s[0] & s[2]) ^ (s[1] & s[2]));
        s[7] = s[6];
        s[6] = s[5];
        s[5] = s[4];
        s[4] = s[3] + t1;
        s[3] = s[2];
        s[2] = s[1];
        s[1] = s[0];
        s[0] = t1 + t2;
      end
      foreach (chain[i]) chain[i] = chain[i] + s[i];
    endfunction

    // Called for every word the block takes, ignored ones included.
    function void note_word(logic [BYTE_W-1:0] b, logic present, logic eom);
      int pos;
      logic [63:0] bit_len;
      if (present) begin
        pos = int'(nbytes[5:0]);
        blk[pos] = b;
        nbytes = nbytes + 1'b1;
        if (nbytes[5:0] == 6'd0) sha_compress();
      end
      if (!eom) return;
      pos = int'(nbytes[5:0]);
      bit_len = {nbytes, 3'b000};
      blk[pos] = PAD_BYTE;
      for (int q = pos + 1; q < 64; q++) blk[q] = '0;
      // No room for the length field: the length goes out in an extra block of its own.
      if (pos >= 56) begin
        sha_compress();
        foreach (blk[i]) blk[i] = '0;
      end
      for (int q = 0; q < 8; q++) blk[63-q] = bit_len[8*q +: 8];
      sha_compress();
      for (int q = 0; q < 8; q++) pending_digest.push_back({chain[q], q == 7});
      restart();
    endfunction

    function void flag(string msg);
      mismatches++;
      if (mismatches <= 10) $display("%s", msg);
    endfunction

    function void check_digest_word(logic [WORD_W-1:0] w, logic last);
      digest_word_t want;
      if (pending_digest.size() == 0) begin
        flag($sformatf("unexpected digest word %08h last=%0b", w, last));
        return;
      end
      want = pending_digest.pop_front();
      if (want.word !== w || want.last !== last)
        flag($sformatf("digest word mismatch: expected %08h last=%0b, got %08h last=%0b",
                       want.word, want.last, w, last));
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [BYTE_W-1:0] in_data_byte = '0;
  logic              in_byte_present = 1'b0;
  logic              in_end_of_message = 1'b0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [WORD_W-1:0] out_digest_word;
  logic              out_digest_last;

  digest_scoreboard sb = new();
  bit               no_gaps = 1'b0;
  int               words_sent = 0;
  int               cycles = 0;

  sha256_stream_hasher dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_data_byte      (in_data_byte),
    .in_byte_present   (in_byte_present),
    .in_end_of_message (in_end_of_message),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_digest_word   (out_digest_word),
    .out_digest_last   (out_digest_last)
  );

  always #CLK_HALF clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("[sha256_stream_hasher] ERROR");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_ready <= no_gaps || ($urandom_range(99) >= IDLE_PCT);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_digest_word(out_digest_word, out_digest_last);
  end

  task automatic send_word(logic [BYTE_W-1:0] b, logic present, logic eom);
    @(negedge clk);
    while (!no_gaps && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid          <= 1'b1;
    in_data_byte      <= b;
    in_byte_present   <= present;
    in_end_of_message <= eom;
    do @(posedge clk); while (!in_ready);
    sb.note_word(b, present, eom);
  endtask

  // Random content; the last byte either rides on the end word or is
  // followed by an end word that carries no byte. Ignored words are mixed in.
  task automatic send_message(int len);
    bit fold_last;
    fold_last = (len > 0) && $urandom_range(1);
    for (int i = 0; i < len; i++) begin
      no_gaps = (words_sent >= 100) && (words_sent < 160);
      if ($urandom_range(99) < 8) send_word(8'($urandom), 1'b0, 1'b0);
      send_word(8'($urandom), 1'b1, fold_last && (i == len - 1));
      words_sent++;
    end
    if (!fold_last) begin
      send_word(8'($urandom), 1'b0, 1'b1);
      words_sent++;
    end
  endtask

  initial begin
    int len;
    int msg_idx;
    repeat (RESET_LEN) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: ignored word, empty message, single bytes both ways, "abc".
    send_word(8'hff, 1'b0, 1'b0);
    send_word(8'h00, 1'b0, 1'b1);
    send_word(8'h00, 1'b1, 1'b0);
    send_word(8'hff, 1'b0, 1'b1);
    send_word(8'hff, 1'b1, 1'b1);
    send_word(8'h61, 1'b1, 1'b0);
    send_word(8'h62, 1'b1, 1'b0);
    send_word(8'h63, 1'b1, 1'b1);
    send_word(8'h00, 1'b0, 1'b0);
    send_word(8'h00, 1'b0, 1'b1);

    // Random messages: first the two sides of the one/two pad block split,
    // then a mix of short messages and lengths around block boundaries.
    msg_idx = 0;
    while (words_sent < RAND_WORDS) begin
      if (msg_idx == 0) len = 55;
      else if (msg_idx == 1) len = 56;
      else if ($urandom_range(99) < 30) begin
        case ($urandom_range(4))
          0:       len = 63;
          1:       len = 64;
          2:       len = 65;
          3:       len = 119;
          default: len = 120;
        endcase
      end else len = $urandom_range(24);
      send_message(len);
      msg_idx++;
    end
    no_gaps = 1'b0;
    @(negedge clk);
    in_valid <= 1'b0;

    while (sb.pending_digest.size() > 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (sb.pending_digest.size() > 0)
      sb.flag($sformatf("%0d digest words never arrived", sb.pending_digest.size()));

    if (sb.mismatches == 0) begin
      $display("[sha256_stream_hasher] OK");
    end else begin
      $display("[sha256_stream_hasher] ERROR");
    end
    $finish;
  end

endmodule
